[design/time_ordered_job_queue_top_defines.svh]
// Assertion macros shared by the time-ordered job queue RTL.
`ifndef TIME_ORDERED_JOB_QUEUE_TOP_DEFINES_SVH
`define TIME_ORDERED_JOB_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define TOJQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define TOJQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tojq_pkg.sv]
// Types and codes shared by the time-ordered job queue modules.
package tojq_pkg;

  localparam int ID_W   = 16;
  localparam int TIME_W = 32;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // Job type that is stored; all others are ignored.
  localparam logic [1:0] TYPE_SMALL = 2'd0;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_IGNORED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_POPPED   = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic [TIME_W-1:0] time_val;
    logic [ID_W-1:0]   id;
  } cell_op_t;

  // Contents of one cell.
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] time_val;
    logic [ID_W-1:0]   id;
  } cell_data_t;

endpackage

[design/tojq_cell.sv]
// One slot of the sorted chain: compares against the broadcast key and shifts.
module tojq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  tojq_pkg::cell_op_t  op_i,
  input  logic                left_keep_i,  // left neighbor keeps its entry
  input  tojq_pkg::cell_data_t left_i,
  input  tojq_pkg::cell_data_t right_i,
  output tojq_pkg::cell_data_t q_o,
  output logic                keep_o
);

  logic                        valid_r;
  logic [tojq_pkg::TIME_W-1:0] time_r;
  logic [tojq_pkg::ID_W-1:0]   id_r;
  tojq_pkg::cell_data_t        cell_nxt;

  assign q_o.valid    = valid_r;
  assign q_o.time_val = time_r;
  assign q_o.id       = id_r;

  // An entry stays put when it is no later than the new key (stable order).
  assign keep_o = valid_r && (time_r <= op_i.time_val);

  // Insert takes the new job at the boundary, the left entry beyond it;
  // pop takes the right entry.
  always_comb begin
    cell_nxt = q_o;
    if (op_i.ins) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          cell_nxt.valid    = 1'b1;
          cell_nxt.time_val = op_i.time_val;
          cell_nxt.id       = op_i.id;
        end else begin
          cell_nxt = left_i;
        end
      end
    end else if (op_i.pop) begin
      cell_nxt = right_i;
    end
  end

  // Valid bit is control state; time and id need no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cell_nxt.valid;
    end
    time_r <= cell_nxt.time_val;
    id_r   <= cell_nxt.id;
  end

endmodule

[design/time_ordered_job_queue_top.sv]
// Time-ordered job queue: a chain of compare-and-shift cells with a result register.
// A result is registered and appears in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while out_tready is high; every cell compares
// against the key in parallel; the per-cell compare plus one shift step sets the cycle.
// Reset clears the cell valid bits, the job count and the output valid at once;
// no clearing pass is needed.
`include "time_ordered_job_queue_top_defines.svh"
module time_ordered_job_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // job_id[15:0], create_time[47:16]
  input  logic [2:0]  in_tuser,   // cmd[0], job_type[2:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // popped_id[15:0], job_count[20:16], zero[23:21]
  output logic [2:0]  out_tuser   // status[2:0]
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic                        in_fire;
  logic                        is_pop;
  logic                        is_small;
  logic                        full;
  logic                        empty;
  logic [CW-1:0]               count_r;
  logic [CW-1:0]               count_nxt;
  logic [CW+4:0]               count_ext;
  logic [2:0]                  status_nxt;
  logic [tojq_pkg::ID_W-1:0]   popped_nxt;
  tojq_pkg::cell_op_t          op;
  tojq_pkg::cell_data_t        cell_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]      keep;
  logic [QUEUE_DEPTH-1:0]      valid_vec;
  logic                        out_tvalid_r;
  logic [2:0]                  status_r;
  logic [tojq_pkg::ID_W-1:0]   popped_r;
  logic [4:0]                  job_count_r;

  // Handshake: the output register frees up as soon as its result is taken.
  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_tvalid_r || out_tready;

  // Command decode.
  assign is_pop   = (in_tuser[0] == tojq_pkg::CMD_POP);
  assign is_small = (in_tuser[2:1] == tojq_pkg::TYPE_SMALL);
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);

  assign op.ins      = in_fire && !is_pop && is_small && !full;
  assign op.pop      = in_fire && is_pop && !empty;
  assign op.time_val = in_tdata[47:16];
  assign op.id       = in_tdata[15:0];

  // Status, popped id and next count.
  always_comb begin
    count_nxt  = count_r;
    popped_nxt = '0;
    if (is_pop) begin
      if (empty) begin
        status_nxt = tojq_pkg::ST_EMPTY;
      end else begin
        status_nxt = tojq_pkg::ST_POPPED;
        popped_nxt = cell_q[0].id;
        count_nxt  = count_r - CW'(1);
      end
    end else if (!is_small) begin
      status_nxt = tojq_pkg::ST_IGNORED;
    end else if (full) begin
      status_nxt = tojq_pkg::ST_FULL;
    end else begin
      status_nxt = tojq_pkg::ST_INSERTED;
      count_nxt  = count_r + CW'(1);
    end
  end

  // Reported count is taken modulo 32.
  assign count_ext = {5'd0, count_nxt};

  // Chain of cells; the ends see an always-keeping left and an empty right.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 left_keep;
    tojq_pkg::cell_data_t left_d;
    tojq_pkg::cell_data_t right_d;

    if (i == 0) begin : g_first
      assign left_keep = 1'b1;
      assign left_d    = '0;
    end else begin : g_mid
      assign left_keep = keep[i-1];
      assign left_d    = cell_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end

    tojq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op_i        (op),
      .left_keep_i (left_keep),
      .left_i      (left_d),
      .right_i     (right_d),
      .q_o         (cell_q[i]),
      .keep_o      (keep[i])
    );

    assign valid_vec[i] = cell_q[i].valid;
  end

  // Count and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      if (in_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    if (in_fire) begin
      status_r    <= status_nxt;
      popped_r    <= popped_nxt;
      job_count_r <= count_ext[4:0];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'd0, job_count_r, popped_r};

  // The valid cells always match the job count.
  `TOJQ_ASSERT_NOW(a_count_matches_cells, 1'b1, $countones(valid_vec) == int'(count_r), "cell valid bits disagree with job count")

  // A pop of a non-empty queue lowers the count by one.
  `TOJQ_ASSERT_NEXT(a_pop_decrements, op.pop, count_r == $past(count_r) - CW'(1), "pop did not decrement job count")

  // Held jobs stay in ascending time order.
  for (genvar k = 0; k < QUEUE_DEPTH - 1; k++) begin : g_order_chk
    `TOJQ_ASSERT_NOW(a_sorted, cell_q[k].valid && cell_q[k+1].valid, cell_q[k].time_val <= cell_q[k+1].time_val, "chain out of time order")
  end

endmodule

[verif/testbench.sv]
// Self-checking testbench for the time-ordered job queue: directed, full-queue and random tests.
module testbench;

  localparam int QUEUE_DEPTH    = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED    = 20;

  // Job types that the queue does not store.
  localparam logic [1:0] TYPE_MEDIUM = 2'd1;
  localparam logic [1:0] TYPE_LARGE  = 2'd2;
  localparam logic [1:0] TYPE_HUGE   = 2'd3;

  // One result transaction as the queue should report it.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] popped_id;
    logic [4:0]  job_count;
  } job_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // job_id[15:0], create_time[47:16]
  logic [2:0]  in_tuser   = '0;   // cmd[0], job_type[2:1]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // popped_id[15:0], job_count[20:16], zero[23:21]
  logic [2:0]  out_tuser;         // status[2:0]

  // Shadow copy of the queue contents, kept in ascending time order.
  logic [31:0] shadow_time [QUEUE_DEPTH];
  logic [15:0] shadow_id   [QUEUE_DEPTH];
  int          shadow_held = 0;
  int          peak_held   = 0;

  job_result_t pending_results[$];
  int          error_count     = 0;
  int          jobs_sent       = 0;
  int          results_checked = 0;
  int          status_seen [5] = '{default: 0};
  int          quiet_cycles    = 0;
  bit          send_idle_on    = 1'b1;
  bit          recv_stall_on   = 1'b1;
  int          stall_left      = 0;

  time_ordered_job_queue_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Print one mismatch line (only the first few) and count it.
  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  // Apply one command to the shadow queue and work out the result it must give.
  task automatic predict_job(input logic cmd, input logic [15:0] id, input logic [31:0] t,
                             input logic [1:0] jt, output job_result_t res);
    int slot;
    res = '0;
    if (cmd == tojq_pkg::CMD_INSERT) begin
      if (jt != tojq_pkg::TYPE_SMALL) begin
        res.status = tojq_pkg::ST_IGNORED;
      end else if (shadow_held >= QUEUE_DEPTH) begin
        res.status = tojq_pkg::ST_FULL;
      end else begin
        // A new job lands after every held job with the same or an earlier time.
        slot = 0;
        while (slot < shadow_held && shadow_time[slot] <= t) slot++;
        for (int i = shadow_held; i > slot; i--) begin
          shadow_time[i] = shadow_time[i-1];
          shadow_id[i]   = shadow_id[i-1];
        end
        shadow_time[slot] = t;
        shadow_id[slot]   = id;
        shadow_held++;
        res.status = tojq_pkg::ST_INSERTED;
      end
    end else if (shadow_held == 0) begin
      res.status = tojq_pkg::ST_EMPTY;
    end else begin
      res.popped_id = shadow_id[0];
      for (int i = 1; i < shadow_held; i++) begin
        shadow_time[i-1] = shadow_time[i];
        shadow_id[i-1]   = shadow_id[i];
      end
      shadow_held--;
      res.status = tojq_pkg::ST_POPPED;
    end
    res.job_count = shadow_held[4:0];
    if (shadow_held > peak_held) peak_held = shadow_held;
    status_seen[res.status]++;
  endtask

  // Drive one transaction, wait for it to be accepted and queue its expected result.
  task automatic send_job(input logic cmd, input logic [15:0] id, input logic [31:0] t,
                          input logic [1:0] jt);
    job_result_t res;
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, id};
    in_tuser  <= {jt, cmd};
    do @(posedge clk); while (!in_tready);
    predict_job(cmd, id, t, jt, res);
    pending_results = {pending_results, res};
    jobs_sent++;
  endtask

  // Pops carry random content in the fields that they do not use.
  task automatic send_pop();
    send_job(tojq_pkg::CMD_POP, 16'($urandom), $urandom, 2'($urandom_range(0, 3)));
  endtask

  // Creation times that favor ties and the ends of the range.
  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 3))
      0:       return 32'($urandom_range(0, 7));
      1:       return 32'hFFFF_FFF8 + 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  // Hold the sender off until every outstanding result has been returned.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Extremes of the fields, every job type, ties, and a pop on an empty queue.
  task automatic test_edge_values();
    send_pop();
    send_job(tojq_pkg::CMD_INSERT, 16'hFFFF, 32'h0000_0005, TYPE_MEDIUM);
    send_job(tojq_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, TYPE_LARGE);
    send_job(tojq_pkg::CMD_INSERT, 16'h0000, 32'h0000_0000, TYPE_HUGE);
    send_job(tojq_pkg::CMD_INSERT, 16'h0000, 32'hFFFF_FFFF, tojq_pkg::TYPE_SMALL);
    send_job(tojq_pkg::CMD_INSERT, 16'hFFFF, 32'h0000_0000, tojq_pkg::TYPE_SMALL);
    send_job(tojq_pkg::CMD_INSERT, 16'h1234, 32'h0000_0000, tojq_pkg::TYPE_SMALL);
    send_job(tojq_pkg::CMD_INSERT, 16'h5678, 32'hFFFF_FFFF, tojq_pkg::TYPE_SMALL);
    send_job(tojq_pkg::CMD_INSERT, 16'h9ABC, 32'h8000_0000, tojq_pkg::TYPE_SMALL);
    repeat (6) send_pop();
  endtask

  // Fill the queue, try to overfill it, then empty it past the bottom.
  task automatic test_full_queue();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_job(tojq_pkg::CMD_INSERT, 16'($urandom), pick_time(), tojq_pkg::TYPE_SMALL);
    end
    send_job(tojq_pkg::CMD_INSERT, 16'($urandom), pick_time(), tojq_pkg::TYPE_SMALL);
    send_job(tojq_pkg::CMD_INSERT, 16'($urandom), pick_time(), TYPE_HUGE);
    send_job(tojq_pkg::CMD_INSERT, 16'($urandom), pick_time(), tojq_pkg::TYPE_SMALL);
    repeat (QUEUE_DEPTH + 2) send_pop();
    wait_results_drained();
  endtask

  // Segments with a random insert/pop mix so the fill level wanders from empty to full.
  task automatic test_random_mix(input int job_total);
    int counted;
    int seg_len;
    int insert_pct;
    logic [1:0] jt;
    counted = 0;
    while (counted < job_total) begin
      seg_len       = $urandom_range(4, 40);
      insert_pct    = $urandom_range(15, 85);
      send_idle_on  = ($urandom_range(0, 3) != 0);
      recv_stall_on = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < seg_len; k++) begin
        if ($urandom_range(0, 99) < insert_pct) begin
          jt = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : tojq_pkg::TYPE_SMALL;
          send_job(tojq_pkg::CMD_INSERT, 16'($urandom), pick_time(), jt);
          if (jt == tojq_pkg::TYPE_SMALL) counted++;
        end else begin
          send_pop();
          counted++;
        end
      end
      if ($urandom_range(0, 29) == 0) wait_results_drained();
    end
  endtask

  // Back-to-back transactions with neither side idling.
  task automatic test_steady_stream(input int job_total);
    send_idle_on  = 1'b0;
    recv_stall_on = 1'b0;
    for (int k = 0; k < job_total; k++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_job(tojq_pkg::CMD_INSERT, 16'($urandom), pick_time(), tojq_pkg::TYPE_SMALL);
      end else begin
        send_pop();
      end
    end
    in_tvalid <= 1'b0;
  endtask

  // Receiver readiness with random stall bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (recv_stall_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare every accepted result against the oldest expectation.
  always @(posedge clk) begin : check_results
    job_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with no transaction pending, status %0d", out_tuser));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_tuser !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", out_tuser, want.status));
        end
        if (out_tdata[15:0] !== want.popped_id) begin
          report_mismatch($sformatf("popped_id %h, expected %h", out_tdata[15:0],
                                    want.popped_id));
        end
        if (out_tdata[20:16] !== want.job_count) begin
          report_mismatch($sformatf("job_count %0d, expected %0d", out_tdata[20:16],
                                    want.job_count));
        end
        if (out_tdata[23:21] !== 3'b000) begin
          report_mismatch($sformatf("pad bits %b, expected zero", out_tdata[23:21]));
        end
      end
    end
  end

  // End the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("No transaction for %0d cycles, %0d results outstanding.", WATCHDOG_LIMIT,
               pending_results.size());
      $display("[time_ordered_job_queue_top] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_values();
    test_full_queue();
    test_random_mix(1220);
    test_steady_stream(220);

    // Let the last results come back, then check that none are left outstanding.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("Sent %0d jobs, checked %0d results; queue peaked at %0d of %0d.", jobs_sent,
             results_checked, peak_held, QUEUE_DEPTH);
    $display("Inserted %0d, ignored %0d, dropped full %0d, popped %0d, empty pops %0d.",
             status_seen[tojq_pkg::ST_INSERTED], status_seen[tojq_pkg::ST_IGNORED],
             status_seen[tojq_pkg::ST_FULL], status_seen[tojq_pkg::ST_POPPED],
             status_seen[tojq_pkg::ST_EMPTY]);
    if (error_count == 0) begin
      $display("[time_ordered_job_queue_top] OK");
    end else begin
      $display("[time_ordered_job_queue_top] ERROR");
    end
    $finish;
  end

endmodule
